// ----- src/clpe_pkg.sv -----
// ----------------------------------------------------------------------------
// clpe_pkg
// Shared sizes, codes, types and pixel helpers for the canvas line/point engine.
// ----------------------------------------------------------------------------
`default_nettype none

package clpe_pkg;

  // Canvas store geometry
  localparam int MAX_WIDTH   = 128;
  localparam int MAX_HEIGHT  = 128;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field widths
  localparam int COORD_W = 12;
  localparam int COLOR_W = 32;
  localparam int DIM_W   = 8;
  localparam int EFFW_W  = $clog2(MAX_WIDTH + 1);
  localparam int EFFH_W  = $clog2(MAX_HEIGHT + 1);
  localparam int ERR_W   = COORD_W + 3;

  // Register port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic REG_IDX_WIDTH  = 1'b0;
  localparam logic REG_IDX_HEIGHT = 1'b1;

  localparam logic [DIM_W-1:0] CANVAS_WIDTH_RST  = DIM_W'(128);
  localparam logic [DIM_W-1:0] CANVAS_HEIGHT_RST = DIM_W'(128);

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_POINT = 2'd1,
    KIND_CLEAR = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [ADDR_W-1:0]         addr_t;

  // True when (x, y) lies on the active canvas
  function automatic logic pix_inside(input coord_t x, input coord_t y,
                                      input logic [EFFW_W-1:0] w,
                                      input logic [EFFH_W-1:0] h);
    logic ok;
    ok = !x[COORD_W-1] && !y[COORD_W-1] &&
         (x[COORD_W-2:0] < w) && (y[COORD_W-2:0] < h);
    return ok;
  endfunction

  // Row-major address, column + row * width; valid only for inside pixels
  function automatic addr_t pix_addr(input coord_t x, input coord_t y,
                                     input logic [EFFW_W-1:0] w);
    addr_t a;
    a = ADDR_W'(y[COORD_W-2:0]) * ADDR_W'(w) + ADDR_W'(x[COORD_W-2:0]);
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- src/clpe_cmd_if.sv -----
// ----------------------------------------------------------------------------
// clpe_cmd_if
// Command channel: valid/ready handshake with one drawing or read command.
// ----------------------------------------------------------------------------
`default_nettype none

interface clpe_cmd_if import clpe_pkg::*; ();

  logic   valid;
  logic   ready;
  kind_t  kind;
  coord_t x_start;
  coord_t y_start;
  coord_t x_end;
  coord_t y_end;
  color_t color;

  modport source (
    output valid, kind, x_start, y_start, x_end, y_end, color,
    input  ready
  );

  modport sink (
    input  valid, kind, x_start, y_start, x_end, y_end, color,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/clpe_rsp_if.sv -----
// ----------------------------------------------------------------------------
// clpe_rsp_if
// Response channel: valid/ready handshake with one pixel read result.
// ----------------------------------------------------------------------------
`default_nettype none

interface clpe_rsp_if import clpe_pkg::*; ();

  logic   valid;
  logic   ready;
  color_t pixel_value;
  logic   in_range;

  modport source (
    output valid, pixel_value, in_range,
    input  ready
  );

  modport sink (
    input  valid, pixel_value, in_range,
    output ready
  );

endinterface

`default_nettype wire

// ----- src/canvas_line_point_engine.sv -----
// ----------------------------------------------------------------------------
// canvas_line_point_engine
// Pixel canvas in one synchronous RAM with line, point, clear and read items.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  cmd     | in        | valid/ready             | kind, x/y start, x/y end, color
//  rsp     | out       | valid/ready             | pixel_value, in_range
//  apb     | in        | psel/penable, pready=1  | canvas_width, canvas_height
//
//  Point writes straight from the item; read registers the RAM data, then
//  waits for a free output register; line draws one pixel per cycle through
//  the single RAM write port; clear writes all STORE_DEPTH words, one word
//  per cycle.
//  Reset (rst, synchronous) returns to idle, drops any pending response and
//  sets both dimensions to 128; the RAM is not cleared, so clear it first.
//  A new item is taken only in idle, and while a read result still waits in
//  the output register; a second read then waits for that register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module canvas_line_point_engine import clpe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  clpe_cmd_if.sink           cmd,
  clpe_rsp_if.source         rsp
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LINE,
    ST_CLEAR,
    ST_READ
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [DIM_W-1:0] canvas_width;
  logic [DIM_W-1:0] canvas_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= CANVAS_WIDTH_RST;
      canvas_height <= CANVAS_HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_IDX_WIDTH:  canvas_width  <= pwdata[DIM_W-1:0];
        REG_IDX_HEIGHT: canvas_height <= pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IDX_WIDTH:  prdata = PDATA_W'(canvas_width);
      REG_IDX_HEIGHT: prdata = PDATA_W'(canvas_height);
      default:        prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Saturate oversized dimensions to the store size
  logic [EFFW_W-1:0] eff_w;
  logic [EFFH_W-1:0] eff_h;

  assign eff_w = (canvas_width  > MAX_WIDTH)  ? EFFW_W'(MAX_WIDTH)  : EFFW_W'(canvas_width);
  assign eff_h = (canvas_height > MAX_HEIGHT) ? EFFH_W'(MAX_HEIGHT) : EFFH_W'(canvas_height);

  // --------------------------------------------------------------------------
  // Control and line state
  // --------------------------------------------------------------------------
  state_t state;

  logic   cmd_fire;
  logic   rsp_fire;

  coord_t cur_x;
  coord_t cur_y;
  coord_t end_x;
  coord_t end_y;
  logic   step_x_neg;
  logic   step_y_neg;
  logic signed [ERR_W-1:0] dx;
  logic signed [ERR_W-1:0] dy;
  logic signed [ERR_W-1:0] err;
  color_t line_color;
  addr_t  clr_addr;
  logic   rd_inside;

  logic   out_valid;
  logic   out_load;
  color_t out_value;
  logic   out_in_range;

  assign cmd.ready       = (state == ST_IDLE);
  assign cmd_fire        = cmd.valid && cmd.ready;
  assign rsp_fire        = out_valid && rsp.ready;
  assign rsp.valid       = out_valid;
  assign rsp.pixel_value = out_value;
  assign rsp.in_range    = out_in_range;

  // Load the output register once the read data is in and the register frees
  assign out_load = (state == ST_READ) && (!out_valid || rsp.ready);

  // Line setup from the incoming item: deltas, step signs, initial error
  logic signed [COORD_W:0] ddx;
  logic signed [COORD_W:0] ddy;
  logic signed [COORD_W:0] adx;
  logic signed [COORD_W:0] ady;

  assign ddx = (COORD_W+1)'(cmd.x_end) - (COORD_W+1)'(cmd.x_start);
  assign ddy = (COORD_W+1)'(cmd.y_end) - (COORD_W+1)'(cmd.y_start);
  assign adx = ddx[COORD_W] ? -ddx : ddx;
  assign ady = ddy[COORD_W] ? -ddy : ddy;

  // One Bresenham step per cycle; pure vertical and horizontal spans fall out
  // of the same recurrence, and the pixel set can depend on direction.
  logic signed [ERR_W:0]   e2;
  logic                    step_x;
  logic                    step_y;
  logic signed [ERR_W-1:0] err_next;
  coord_t                  cur_x_next;
  coord_t                  cur_y_next;
  logic                    line_done;

  always_comb begin
    e2     = {err, 1'b0};
    step_x = e2 > -((ERR_W+1)'(dy));
    step_y = e2 < (ERR_W+1)'(dx);
    err_next = err;
    if (step_x) begin
      err_next = err_next - dy;
    end
    if (step_y) begin
      err_next = err_next + dx;
    end
    cur_x_next = cur_x;
    if (step_x) begin
      cur_x_next = step_x_neg ? cur_x - coord_t'(1) : cur_x + coord_t'(1);
    end
    cur_y_next = cur_y;
    if (step_y) begin
      cur_y_next = step_y_neg ? cur_y - coord_t'(1) : cur_y + coord_t'(1);
    end
    line_done = (cur_x == end_x) && (cur_y == end_y);
  end

  // --------------------------------------------------------------------------
  // RAM port selection
  // --------------------------------------------------------------------------
  logic   wr_en;
  addr_t  wr_addr;
  color_t wr_data;
  logic   rd_en;
  addr_t  rd_addr;
  color_t rd_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pix_addr(cur_x, cur_y, eff_w);
    wr_data = line_color;
    rd_en   = cmd_fire && (cmd.kind == KIND_READ);
    rd_addr = pix_addr(cmd.x_start, cmd.y_start, eff_w);
    unique case (state)
      ST_IDLE: begin
        // Point: write straight from the item, clipped
        if (cmd_fire && cmd.kind == KIND_POINT) begin
          wr_en   = pix_inside(cmd.x_start, cmd.y_start, eff_w, eff_h);
          wr_addr = pix_addr(cmd.x_start, cmd.y_start, eff_w);
          wr_data = cmd.color;
        end
      end
      ST_LINE: begin
        // Drop pixels off the canvas
        wr_en = pix_inside(cur_x, cur_y, eff_w, eff_h);
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
      end
      default: ;
    endcase
  end

  // Pixel store: one write port, one registered read port
  color_t pixel_store [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pixel_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= pixel_store[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            unique case (cmd.kind)
              KIND_LINE: begin
                cur_x      <= cmd.x_start;
                cur_y      <= cmd.y_start;
                end_x      <= cmd.x_end;
                end_y      <= cmd.y_end;
                step_x_neg <= ddx[COORD_W];
                step_y_neg <= ddy[COORD_W];
                dx         <= ERR_W'(adx);
                dy         <= ERR_W'(ady);
                err        <= ERR_W'(adx) - ERR_W'(ady);
                line_color <= cmd.color;
                state      <= ST_LINE;
              end
              KIND_CLEAR: begin
                clr_addr   <= '0;
                line_color <= cmd.color;
                state      <= ST_CLEAR;
              end
              KIND_READ: begin
                rd_inside <= pix_inside(cmd.x_start, cmd.y_start, eff_w, eff_h);
                state     <= ST_READ;
              end
              default: ;
            endcase
          end
        end
        ST_LINE: begin
          // Plot current pixel, then advance or finish at the end point
          if (line_done) begin
            state <= ST_IDLE;
          end else begin
            cur_x <= cur_x_next;
            cur_y <= cur_y_next;
            err   <= err_next;
          end
        end
        ST_CLEAR: begin
          if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + addr_t'(1);
          end
        end
        ST_READ: begin
          // Hold RAM data until the output register frees up
          if (out_load) begin
            out_value    <= rd_inside ? rd_data : '0;
            out_in_range <= rd_inside;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
